// ----- src/ttlc_pkg.sv -----
package ttlc_pkg;

  // Request kinds
  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_GET_HIT      = 3'd0;
  localparam logic [2:0] ST_GET_MISS     = 3'd1;
  localparam logic [2:0] ST_SET_INSERTED = 3'd2;
  localparam logic [2:0] ST_SET_UPDATED  = 3'd3;
  localparam logic [2:0] ST_SET_FULL     = 3'd4;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam logic [6:0]  LIVE_MAX = 7'd127;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
    logic [63:0] data_value;
    logic [15:0] ttl_seconds;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [6:0]  live_count;
  } rsp_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic tok;   // token present at this stage
    logic hit;   // a live slot upstream holds the key
    logic free;  // a free slot has been seen upstream
  } link_t;

endpackage

// ----- src/ttlc_cell.sv -----
module ttlc_cell import ttlc_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64,
  parameter int IDX_BITS   = 6,
  parameter int CNT_BITS   = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  is_set,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [31:0]           expiry_set,
  input  logic [31:0]           now,
  input  logic                  ins_en,
  input  logic [IDX_BITS-1:0]   ins_idx,
  input  link_t                 lnk_in,
  input  logic [IDX_BITS-1:0]   idx_in,
  input  logic [CNT_BITS-1:0]   cnt_in,
  input  logic [VALUE_BITS-1:0] rdata_in,
  output link_t                 lnk_out,
  output logic [IDX_BITS-1:0]   idx_out,
  output logic [CNT_BITS-1:0]   cnt_out,
  output logic [VALUE_BITS-1:0] rdata_out
);

  logic                  valid;
  logic [KEY_BITS-1:0]   slot_key;
  logic [VALUE_BITS-1:0] slot_value;
  logic [31:0]           slot_expiry;

  logic expired;
  logic live;
  logic match;
  logic ins_sel;

  // Classify this slot against the passing transaction
  assign expired = valid && (slot_expiry <= now);
  assign live    = valid && !expired;
  assign match   = live && (slot_key == key);
  assign ins_sel = ins_en && (ins_idx == IDX_BITS'(INDEX));

  // Drop the slot on expiry, claim it on insert; advance the token
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      lnk_out <= '0;
    end else begin
      if (lnk_in.tok && expired) begin
        valid <= 1'b0;
      end
      if (ins_sel) begin
        valid <= 1'b1;
      end
      lnk_out.tok  <= lnk_in.tok;
      lnk_out.hit  <= lnk_in.hit || match;
      lnk_out.free <= lnk_in.free || !live;
    end
  end

  // Slot contents: refresh on update, fill on insert
  always_ff @(posedge clk) begin
    if (lnk_in.tok && match && is_set) begin
      slot_value  <= value;
      slot_expiry <= expiry_set;
    end
    if (ins_sel) begin
      slot_key    <= key;
      slot_value  <= value;
      slot_expiry <= expiry_set;
    end
  end

  // Hand the running search result to the next cell
  always_ff @(posedge clk) begin
    idx_out   <= lnk_in.free ? idx_in : IDX_BITS'(INDEX);
    cnt_out   <= cnt_in + CNT_BITS'(live);
    rdata_out <= match ? slot_value : rdata_in;
  end

endmodule

// ----- src/ttl_key_value_cache.sv -----
// Key/value table of ENTRIES slots, each with an expiry time. A transaction is
// taken when start is high and busy is low. A search token then walks the row
// of slot cells one cell per clock, expiring stale slots, matching the key,
// noting the lowest free slot and counting live ones on its way, and busy
// stays high until the token leaves the row. An insert is
// written into the free slot as the token leaves the last cell, and the
// result appears on rsp with done high for exactly one cycle after that. The
// receiver cannot stall results: done is a strobe and rsp must be sampled in
// that cycle. The next transaction may be accepted in the cycle done is high.
module ttl_key_value_cache import ttlc_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);

  logic                  launch;
  logic                  is_set;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic [31:0]           expiry_set;
  logic [31:0]           now;

  link_t                 lnk   [ENTRIES+1];
  logic [IDX_BITS-1:0]   idx   [ENTRIES+1];
  logic [CNT_BITS-1:0]   cnt   [ENTRIES+1];
  logic [VALUE_BITS-1:0] rdata [ENTRIES+1];
  logic [ENTRIES-1:0]    tok_vec;

  logic                  accept;
  logic [32:0]           exp_sum;
  logic                  ins_en;
  logic                  finish;
  logic [CNT_BITS-1:0]   live_sum;
  logic [2:0]            status_next;

  assign accept  = start && !busy;
  assign exp_sum = {1'b0, req.now_time} + 33'(req.ttl_seconds);

  // Control: hold busy from acceptance until the token leaves the row
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= accept;
      done   <= finish;
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  // Capture the transaction; it is broadcast to every cell during the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      is_set     <= (req.func == FUNC_SET);
      key        <= req.key[KEY_BITS-1:0];
      value      <= req.data_value[VALUE_BITS-1:0];
      expiry_set <= exp_sum[32] ? TIME_MAX : exp_sum[31:0];
      now        <= req.now_time;
    end
  end

  // Seed the head of the row
  assign lnk[0].tok  = launch;
  assign lnk[0].hit  = 1'b0;
  assign lnk[0].free = 1'b0;
  assign idx[0]      = '0;
  assign cnt[0]      = '0;
  assign rdata[0]    = '0;

  // Row of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ttlc_cell #(
      .INDEX      (i),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_BITS   (IDX_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .is_set     (is_set),
      .key        (key),
      .value      (value),
      .expiry_set (expiry_set),
      .now        (now),
      .ins_en     (ins_en),
      .ins_idx    (idx[ENTRIES]),
      .lnk_in     (lnk[i]),
      .idx_in     (idx[i]),
      .cnt_in     (cnt[i]),
      .rdata_in   (rdata[i]),
      .lnk_out    (lnk[i+1]),
      .idx_out    (idx[i+1]),
      .cnt_out    (cnt[i+1]),
      .rdata_out  (rdata[i+1])
    );
    assign tok_vec[i] = lnk[i+1].tok;
  end

  // Resolve the transaction as the token leaves the last cell
  assign finish   = lnk[ENTRIES].tok;
  assign ins_en   = finish && is_set && !lnk[ENTRIES].hit && lnk[ENTRIES].free;
  assign live_sum = cnt[ENTRIES] + CNT_BITS'(ins_en);

  always_comb begin
    if (is_set) begin
      if (lnk[ENTRIES].hit) begin
        status_next = ST_SET_UPDATED;
      end else if (lnk[ENTRIES].free) begin
        status_next = ST_SET_INSERTED;
      end else begin
        status_next = ST_SET_FULL;
      end
    end else begin
      status_next = lnk[ENTRIES].hit ? ST_GET_HIT : ST_GET_MISS;
    end
  end

  // Result register, shown for one cycle under done
  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.status     <= status_next;
      rsp.read_value <= (!is_set && lnk[ENTRIES].hit) ? 64'(rdata[ENTRIES]) : 64'd0;
      rsp.live_count <= (32'(live_sum) > 32'(LIVE_MAX)) ? LIVE_MAX : 7'(live_sum);
    end
  end

  // At most one search token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({launch, tok_vec}))
    else $error("more than one search token in flight");

  // An accepted transaction keeps the block busy
  a_busy_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after acceptance");

  // A result is shown only once the walk has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(finish))
    else $error("result strobe while a walk is in progress");

  // Live count never exceeds the table size
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(rsp.live_count) <= 32'(ENTRIES))
    else $error("live count above table size");

endmodule
